### rtl/bmq_pkg.sv
`default_nettype none

package bmq_pkg;

   localparam int TASK_ID_BITS = 3;
   localparam int CSR_BITS     = 5;

   localparam logic [CSR_BITS-1:0] DEPTH_RESET = 5'd16;

   typedef enum logic {
      CMD_SEND = 1'b0,
      CMD_RECV = 1'b1
   } command_type;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_BLOCKED = 1'b1;

   typedef struct packed {
      logic                    go;
      command_type             command;
      logic                    blocked;
      logic [TASK_ID_BITS-1:0] task_id;
   } req_ctl_type;

   typedef struct packed {
      logic                    woke;
      logic [TASK_ID_BITS-1:0] task_id;
   } wake_type;

endpackage

`default_nettype wire

### rtl/bmq_if.sv
`default_nettype none

interface bmq_req_if #(parameter int WORD_BITS = 32);
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic [bmq_pkg::TASK_ID_BITS-1:0]  task_id;
   logic [WORD_BITS-1:0]              message_in;

   modport source (output valid, command, task_id, message_in, input ready);
   modport sink   (input valid, command, task_id, message_in, output ready);
endinterface

interface bmq_rsp_if #(parameter int WORD_BITS = 32);
   logic                              valid;
   logic                              ready;
   logic                              status;
   logic [WORD_BITS-1:0]              message_out;
   logic                              woke_valid;
   logic [bmq_pkg::TASK_ID_BITS-1:0]  woken_task;

   modport source (output valid, status, message_out, woke_valid, woken_task, input ready);
   modport sink   (input valid, status, message_out, woke_valid, woken_task, output ready);
endinterface

interface bmq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bmq_pkg::CSR_BITS-1:0]  depth_in_use;

   modport source (output valid, depth_in_use, input ready);
   modport sink   (input valid, depth_in_use, output ready);
endinterface

`default_nettype wire

### rtl/blocking_message_queue_unit.sv
// Blocking message queue with task wait lists.
// req_bus carries one request beat: command (send or receive), task_id and
// message_in. rsp_bus returns exactly one beat per request: status (done or
// blocked), message_out (the dequeued word on a successful receive, else
// zero), woke_valid and woken_task for a waiter released from the opposite
// wait list. csr_bus writes depth_in_use, the ring capacity; write it only
// while no request is outstanding.
// A new request is taken only once the previous one is through: the ring
// and wait-link memories are read, then the pop commit and response load
// follow, and req_bus.ready stays low until then.
// A finished response waits in the output register while the next request
// is taken; if that response is still not taken when the next one is ready,
// the block holds it and keeps req_bus.ready low until rsp_bus.ready rises.
// Reset empties the ring and both wait lists and sets depth_in_use to 16
// (capacity at most DEPTH); ring contents are left as they are.
`default_nettype none

module blocking_message_queue_unit #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32,
   parameter int TASKS     = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bmq_req_if.sink    req_bus,
   bmq_rsp_if.source  rsp_bus,
   bmq_csr_if.sink    csr_bus
);

   localparam int CAP_BITS = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                         state_ff;
   logic                              rsp_valid_ff;
   logic                              status_ff;
   logic [WORD_BITS-1:0]              message_ff;
   logic                              woke_ff;
   logic [bmq_pkg::TASK_ID_BITS-1:0]  woken_ff;

   bmq_pkg::command_type              command_ff;
   logic                              blocked_ff;
   bmq_pkg::wake_type                 wake_ff;

   logic [bmq_pkg::CSR_BITS-1:0]      depth_ff;

   logic                              accept;
   logic                              load;
   bmq_pkg::command_type              command;
   logic [CAP_BITS-1:0]               capacity;
   logic                              blocked;
   logic [WORD_BITS-1:0]              ring_data;
   logic [WORD_BITS-1:0]              message_in;
   bmq_pkg::req_ctl_type              ctl;
   bmq_pkg::wake_type                 wake;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign command       = bmq_pkg::command_type'(req_bus.command);
   assign load          = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      if (depth_ff == '0) begin
         capacity = CAP_BITS'(1);
      end else if (int'(depth_ff) > DEPTH) begin
         capacity = CAP_BITS'(DEPTH);
      end else begin
         capacity = CAP_BITS'(depth_ff);
      end
   end

   assign ctl.go      = accept;
   assign ctl.command = command;
   assign ctl.blocked = blocked;
   assign ctl.task_id = req_bus.task_id;

   always_comb begin
      message_in = '0;
      if ((command_ff == bmq_pkg::CMD_RECV) && !blocked_ff) begin
         message_in = ring_data;
      end
   end

   bmq_ring #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .go       (accept),
      .command  (command),
      .message  (req_bus.message_in),
      .capacity (capacity),
      .blocked  (blocked),
      .rd_data  (ring_data)
   );

   bmq_wait #(
      .TASKS (TASKS)
   ) u_wait (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .wake  (wake)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         command_ff <= command;
         blocked_ff <= blocked;
         wake_ff    <= wake;
      end
      if (load) begin
         status_ff  <= blocked_ff ? bmq_pkg::STATUS_BLOCKED : bmq_pkg::STATUS_DONE;
         message_ff <= message_in;
         woke_ff    <= wake_ff.woke;
         woken_ff   <= wake_ff.task_id;
      end
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= bmq_pkg::DEPTH_RESET;
      end else if (csr_bus.valid) begin
         depth_ff <= csr_bus.depth_in_use;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.message_out = message_ff;
   assign rsp_bus.woke_valid  = woke_ff;
   assign rsp_bus.woken_task  = woken_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("second request taken while one is in flight");

   a_blocked_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == bmq_pkg::STATUS_BLOCKED)
         |-> (rsp_bus.message_out == '0) && !rsp_bus.woke_valid)
      else $error("blocked response carries data or a wake");

endmodule

`default_nettype wire

### rtl/bmq_ram.sv
`default_nettype none

module bmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_BITS-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_BITS-1:0]  rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/bmq_ring.sv
`default_nettype none

module bmq_ring #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32,
   localparam int CAP_BITS = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  bmq_pkg::command_type       command,
   input  wire logic [WORD_BITS-1:0]  message,
   input  wire logic [CAP_BITS-1:0]   capacity,
   output logic                       blocked,
   output logic      [WORD_BITS-1:0]  rd_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CAP_BITS-1:0] fill_ff, fill_in;
   logic                full;
   logic                empty;
   logic                do_write;
   logic                do_read;

   function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] ptr,
                                                   input logic [CAP_BITS-1:0] cap);
      logic [CAP_BITS:0] nxt;
      nxt = (CAP_BITS + 1)'(ptr) + (CAP_BITS + 1)'(1);
      if (nxt >= (CAP_BITS + 1)'(cap)) begin
         return '0;
      end
      return PTR_BITS'(nxt);
   endfunction

   assign full     = (fill_ff >= capacity);
   assign empty    = (fill_ff == '0);
   assign blocked  = (command == bmq_pkg::CMD_SEND) ? full : empty;
   assign do_write = go && (command == bmq_pkg::CMD_SEND) && !full;
   assign do_read  = go && (command == bmq_pkg::CMD_RECV) && !empty;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (do_write) begin
         tail_in = advance(tail_ff, capacity);
         fill_in = fill_ff + CAP_BITS'(1);
      end
      if (do_read) begin
         head_in = advance(head_ff, capacity);
         fill_in = fill_ff - CAP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   bmq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (tail_ff),
      .wr_data (message),
      .rd_en   (do_read),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= DEPTH)
      else $error("fill count beyond ring depth");

endmodule

`default_nettype wire

### rtl/bmq_wait.sv
`default_nettype none

module bmq_wait #(
   parameter int TASKS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  bmq_pkg::req_ctl_type ctl,
   output bmq_pkg::wake_type  wake
);

   localparam int LINK_BITS = $clog2(TASKS + 1);
   localparam int TASK_BITS = $clog2(TASKS);
   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(TASKS);

   logic [LINK_BITS-1:0] writer_top_ff;
   logic [LINK_BITS-1:0] reader_top_ff;
   logic [TASKS-1:0]     valid_ff;
   logic                 pop_pending_ff;
   logic                 pop_writer_ff;
   logic [LINK_BITS-1:0] pop_task_ff;

   logic [LINK_BITS-1:0] push_top;
   logic [LINK_BITS-1:0] pop_top;
   logic                 task_ok;
   logic                 pop_hit;
   logic                 do_push;
   logic                 do_pop;
   logic [TASK_BITS-1:0] push_idx;
   logic [TASK_BITS-1:0] pop_idx;
   logic [LINK_BITS-1:0] link_rd;
   logic [LINK_BITS-1:0] top_in;

   always_comb begin
      if (ctl.command == bmq_pkg::CMD_SEND) begin
         push_top = writer_top_ff;
         pop_top  = reader_top_ff;
      end else begin
         push_top = reader_top_ff;
         pop_top  = writer_top_ff;
      end
   end

   assign task_ok  = int'(ctl.task_id) < TASKS;
   assign pop_hit  = int'(pop_top) < TASKS;
   assign do_push  = ctl.go && ctl.blocked && task_ok;
   assign do_pop   = ctl.go && !ctl.blocked && pop_hit;
   assign push_idx = TASK_BITS'(ctl.task_id);
   assign pop_idx  = pop_task_ff[TASK_BITS-1:0];
   assign top_in   = valid_ff[pop_idx] ? link_rd : NULL_LINK;

   assign wake.woke    = do_pop;
   assign wake.task_id = do_pop ? bmq_pkg::TASK_ID_BITS'(pop_top) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         writer_top_ff  <= NULL_LINK;
         reader_top_ff  <= NULL_LINK;
         valid_ff       <= '0;
         pop_pending_ff <= 1'b0;
      end else begin
         // commit the pop of the previous beat once its link is back
         if (pop_pending_ff) begin
            valid_ff[pop_idx] <= 1'b0;
            if (pop_writer_ff) begin
               writer_top_ff <= top_in;
            end else begin
               reader_top_ff <= top_in;
            end
         end
         if (do_push) begin
            valid_ff[push_idx] <= 1'b1;
            if (ctl.command == bmq_pkg::CMD_SEND) begin
               writer_top_ff <= LINK_BITS'(ctl.task_id);
            end else begin
               reader_top_ff <= LINK_BITS'(ctl.task_id);
            end
         end
         pop_pending_ff <= do_pop;
      end
      if (do_pop) begin
         pop_writer_ff <= (ctl.command == bmq_pkg::CMD_RECV);
         pop_task_ff   <= pop_top;
      end
   end

   bmq_ram #(
      .WIDTH (LINK_BITS),
      .DEPTH (TASKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (push_idx),
      .wr_data (push_top),
      .rd_en   (do_pop),
      .rd_addr (pop_top[TASK_BITS-1:0]),
      .rd_data (link_rd)
   );

   a_block_no_wake: assert property (@(posedge clock) disable iff (reset)
      ctl.go && ctl.blocked |-> !wake.woke)
      else $error("blocked beat released a waiter");

   a_pop_no_overlap: assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |-> !ctl.go)
      else $error("request overlaps pending pop");

endmodule

`default_nettype wire
